// ===== design/periodic_task_table_unit_defines.svh =====
// Assertion macros for the periodic task table.
`ifndef PERIODIC_TASK_TABLE_UNIT_DEFINES_SVH
`define PERIODIC_TASK_TABLE_UNIT_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define PTT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define PTT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== design/ptt_pkg.sv =====
// Package for the periodic task table: constants, codes, state type, slot record.
`default_nettype none
package ptt_pkg;
    localparam int SLOTS     = 16;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int TIME_BITS = 64;
    localparam int ID_W      = 31;
    localparam logic [ID_W-1:0] ID_INVALID = {ID_W{1'b1}};

    localparam logic [1:0] CMD_SCHED = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_REM   = 2'd2;
    localparam logic [1:0] CMD_QUERY = 2'd3;

    localparam logic [2:0] KIND_SCHED = 3'd0;
    localparam logic [2:0] KIND_FIRED = 3'd1;
    localparam logic [2:0] KIND_REM   = 3'd2;
    localparam logic [2:0] KIND_PER   = 3'd3;
    localparam logic [2:0] KIND_DONE  = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,     // issue memory read of r_idx
        ST_WAIT,   // read data returns
        ST_EVAL,   // act on the slot
        ST_GCD,    // run binary GCD on r_ga, r_gb
        ST_SHIFT,  // remove: move slot r_idx down by one
        ST_EMIT,   // present result, wait for the sink
        ST_FIN     // final result beat
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0]      id;
        logic [TIME_BITS-1:0] period;
        logic [TIME_BITS-1:0] deadline;
        logic                 mode;
    } t_slot;
endpackage
`default_nettype wire

// ===== design/periodic_task_table_unit.sv =====
// Top level of the periodic task table: command sequencer over a slot memory.
//   channel | direction | handshake             | payload
//   in      | sink      | i_valid / o_ready     | i_command i_now_time i_period i_mode i_task_id
//   out     | source    | o_valid / i_ready     | o_kind o_result_id o_ok o_tick_period o_last
// One command at a time. Schedule writes the slot on acceptance and goes straight to
// the final beat. Remove reads each occupied slot in turn (search, then shift of the
// later slots). Tick reads each occupied slot and emits a beat for each one that
// fires. Query reads each slot and folds each nonzero period into a binary GCD.
// Reset (synchronous, active low) empties the table and clears the id counter.
// A stalled result beat holds the sequencer; the next command waits for o_ready.
`default_nettype none
`include "periodic_task_table_unit_defines.svh"
module periodic_task_table_unit
    import ptt_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [1:0]           i_command,
    input  wire logic [63:0]          i_now_time,
    input  wire logic [63:0]          i_period,
    input  wire logic                 i_mode,
    input  wire logic [ID_W-1:0]      i_task_id,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [2:0]                o_kind,
    output logic [ID_W-1:0]           o_result_id,
    output logic                      o_ok,
    output logic [63:0]               o_tick_period,
    output logic                      o_last
);
    // Slot memory: one write port, one registered read port.
    t_slot mem [SLOTS];
    t_slot r_rd;
    logic [SLOT_W-1:0] mem_raddr, mem_waddr;
    logic mem_we;
    t_slot mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= mem[mem_raddr];
    end

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_used;
    logic [ID_W-1:0]  r_idc;
    logic [CNT_W-1:0] r_idx;
    logic [1:0]       r_cmd;
    logic [TIME_BITS-1:0] r_now;
    logic [ID_W-1:0]  r_tid;
    logic             r_found;
    logic [TIME_BITS-1:0] r_ga, r_gb;
    logic [6:0]       r_gsh;
    // Output register
    logic             r_ov;
    logic [2:0]       r_kind;
    logic [ID_W-1:0]  r_rid;
    logic             r_ok;
    logic [63:0]      r_tp;
    logic             r_last;

    assign o_valid       = r_ov;
    assign o_kind        = r_kind;
    assign o_result_id   = r_rid;
    assign o_ok          = r_ok;
    assign o_tick_period = r_tp;
    assign o_last        = r_last;
    assign o_ready       = (r_state == ST_IDLE) && (!r_ov || i_ready);

    logic in_acc, out_free;
    assign in_acc   = i_valid && o_ready;
    assign out_free = !r_ov || i_ready;

    logic [CNT_W:0] idx_p1;
    assign idx_p1 = {1'b0, r_idx} + 1'b1;

    logic due;
    assign due = r_rd.deadline <= r_now;

    t_slot fire_wr;
    always_comb begin
        fire_wr = r_rd;
        fire_wr.deadline = (r_rd.mode ? r_rd.deadline : r_now) + r_rd.period;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_command == CMD_SCHED) begin
                        n_state = ST_FIN;
                    end else if (r_used == '0) begin
                        n_state = ST_FIN;
                    end else begin
                        n_state = ST_RD;
                    end
                end
            end
            ST_RD:   n_state = ST_WAIT;
            ST_WAIT: n_state = ST_EVAL;
            ST_EVAL: begin
                if (r_cmd == CMD_TICK && due) begin
                    n_state = ST_EMIT;
                end else if (r_cmd == CMD_QUERY && r_rd.period != '0 && r_ga != '0) begin
                    n_state = ST_GCD;
                end else if (r_cmd == CMD_REM && r_rd.id == r_tid) begin
                    n_state = (idx_p1 >= (CNT_W+1)'(r_used)) ? ST_FIN : ST_SHIFT;
                end else begin
                    n_state = (idx_p1 >= (CNT_W+1)'(r_used)) ? ST_FIN : ST_RD;
                end
            end
            ST_GCD: begin
                // r_idx already points at the next slot here
                if (r_gb == '0) begin
                    n_state = (r_idx >= r_used) ? ST_FIN : ST_RD;
                end
            end
            ST_SHIFT: n_state = ST_WAIT;
            ST_EMIT: begin
                if (out_free) begin
                    n_state = (idx_p1 >= (CNT_W+1)'(r_used)) ? ST_FIN : ST_RD;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Memory port control
    always_comb begin
        mem_raddr = r_idx[SLOT_W-1:0];
        mem_we    = 1'b0;
        mem_waddr = r_idx[SLOT_W-1:0];
        mem_wdata = fire_wr;
        case (r_state)
            ST_IDLE: begin
                mem_waddr = r_used[SLOT_W-1:0];
                mem_wdata.id       = r_idc;
                mem_wdata.period   = i_period;
                mem_wdata.deadline = i_now_time + i_period;
                mem_wdata.mode     = i_mode;
                mem_we = in_acc && i_command == CMD_SCHED && r_used < CNT_W'(SLOTS)
                         && r_idc != ID_INVALID;
            end
            ST_EVAL: begin
                if (r_cmd == CMD_TICK && due) begin
                    mem_we = 1'b1;
                end else if (r_cmd == CMD_REM && r_found) begin
                    mem_we    = 1'b1;
                    mem_waddr = SLOT_W'(r_idx - 1'b1);
                    mem_wdata = r_rd;
                end
            end
            default: ;
        endcase
    end

    // Datapath and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_used  <= '0;
            r_idc   <= '0;
            r_ov    <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            // a new beat loaded below keeps valid high
            if (r_ov && i_ready
                && !(out_free && (r_state == ST_EMIT || r_state == ST_FIN))) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_cmd   <= i_command;
                        r_now   <= i_now_time;
                        r_tid   <= i_task_id;
                        r_idx   <= '0;
                        r_found <= 1'b0;
                        r_ga    <= '0;
                        r_gb    <= '0;
                        r_gsh   <= '0;
                        r_tp    <= '0;
                        case (i_command)
                            CMD_SCHED: begin
                                r_kind <= KIND_SCHED;
                                r_rid  <= mem_we ? r_idc : ID_INVALID;
                                r_ok   <= mem_we;
                                if (mem_we) begin
                                    r_idc  <= r_idc + 1'b1;
                                    r_used <= r_used + 1'b1;
                                end
                            end
                            CMD_REM: begin
                                r_kind <= KIND_REM;
                                r_rid  <= i_task_id;
                                r_ok   <= 1'b0;
                            end
                            CMD_QUERY: begin
                                r_kind <= KIND_PER;
                                r_rid  <= ID_INVALID;
                                r_ok   <= 1'b0;
                            end
                            default: begin
                                r_kind <= KIND_DONE;
                                r_rid  <= ID_INVALID;
                                r_ok   <= 1'b0;
                            end
                        endcase
                    end
                end
                ST_EVAL: begin
                    if (r_cmd == CMD_QUERY && r_rd.period != '0) begin
                        if (r_ga == '0) begin
                            r_ga <= r_rd.period;
                        end else begin
                            r_gb  <= r_rd.period;
                            r_gsh <= '0;
                        end
                    end
                    if (r_cmd == CMD_REM && !r_found && r_rd.id == r_tid) begin
                        r_found <= 1'b1;
                        r_ok    <= 1'b1;
                    end
                    if (!(r_cmd == CMD_TICK && due)) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    if (r_cmd == CMD_REM && (r_found || r_rd.id == r_tid)
                        && idx_p1 >= (CNT_W+1)'(r_used)) begin
                        r_used <= r_used - 1'b1;
                    end
                end
                ST_GCD: begin
                    // binary GCD: one step per cycle; result = r_ga << r_gsh
                    if (r_gb == '0) begin
                        r_ga  <= r_ga << r_gsh;
                    end else if (!r_ga[0] && !r_gb[0]) begin
                        r_ga  <= r_ga >> 1;
                        r_gb  <= r_gb >> 1;
                        r_gsh <= r_gsh + 1'b1;
                    end else if (!r_ga[0]) begin
                        r_ga <= r_ga >> 1;
                    end else if (!r_gb[0]) begin
                        r_gb <= r_gb >> 1;
                    end else if (r_ga > r_gb) begin
                        r_ga <= r_ga - r_gb;
                    end else begin
                        r_gb <= r_gb - r_ga;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_ov   <= 1'b1;
                        r_kind <= KIND_FIRED;
                        r_rid  <= r_rd.id;
                        r_ok   <= 1'b0;
                        r_tp   <= '0;
                        r_last <= 1'b0;
                        r_idx  <= r_idx + 1'b1;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        r_ov   <= 1'b1;
                        r_last <= 1'b1;
                        if (r_cmd == CMD_TICK) begin
                            r_kind <= KIND_DONE;
                            r_rid  <= ID_INVALID;
                            r_ok   <= 1'b0;
                        end
                        if (r_cmd == CMD_QUERY) begin
                            r_tp <= r_ga;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    `PTT_ASSERT_IMP(a_used_bound, i_clk, i_rst_n, 1'b1, r_used <= CNT_W'(SLOTS),
        "slot count exceeds table size")
    `PTT_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_state != ST_IDLE, !o_ready,
        "input accepted while busy")
    `PTT_ASSERT_NEXT(a_fin_last, i_clk, i_rst_n, r_state == ST_FIN && out_free,
        o_valid && o_last, "final beat missing last")
endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the periodic task table: directed table, then random traffic.
`timescale 1ns / 100ps
module tb
    import ptt_pkg::*;
;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_valid;
    logic            o_ready;
    logic [1:0]      i_command;
    logic [63:0]     i_now_time;
    logic [63:0]     i_period;
    logic            i_mode;
    logic [ID_W-1:0] i_task_id;
    logic            o_valid;
    logic            i_ready;
    logic [2:0]      o_kind;
    logic [ID_W-1:0] o_result_id;
    logic            o_ok;
    logic [63:0]     o_tick_period;
    logic            o_last;

    periodic_task_table_unit uut (.*);

    // one expected result beat
    typedef struct packed {
        logic [2:0]      kind;
        logic [ID_W-1:0] rid;
        logic            ok;
        logic [63:0]     tp;
        logic            last;
    } t_beat;

    // one directed row; chk set where the answer is typed in by hand
    typedef struct {
        logic [1:0]      cmd;
        logic [63:0]     now;
        logic [63:0]     per;
        logic            mode;
        logic [ID_W-1:0] tid;
        bit              chk;
        t_beat           want;
    } t_row;

    // predictor copy of the table
    bit              tbl_used [SLOTS];
    logic [ID_W-1:0] tbl_id   [SLOTS];
    logic [63:0]     tbl_per  [SLOTS];
    logic [63:0]     tbl_dl   [SLOTS];
    logic            tbl_mode [SLOTS];
    logic [ID_W-1:0] next_id;

    t_beat  pending_beats[$];
    int     errors;
    int     idle_in_pct;
    int     idle_out_pct;
    int     hold_sink;
    int     quiet_cycles;
    logic [ID_W-1:0] issued_ids[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_beat mk(logic [2:0] k, logic [ID_W-1:0] r, logic ok,
                                 logic [63:0] tp, logic last);
        t_beat b;
        b.kind = k; b.rid = r; b.ok = ok; b.tp = tp; b.last = last;
        return b;
    endfunction

    function automatic logic [63:0] gcd_of(logic [63:0] a, logic [63:0] b);
        logic [63:0] t;
        while (b != 0) begin
            t = b;
            b = a % b;
            a = t;
        end
        return a;
    endfunction

    function automatic int occupied();
        int n;
        n = 0;
        while (n < SLOTS && tbl_used[n]) n++;
        return n;
    endfunction

    // advance the table by one command and queue the beats it produces
    task automatic predict_table(logic [1:0] cmd, logic [63:0] now, logic [63:0] per,
                                 logic mode, logic [ID_W-1:0] tid);
        int n;
        int found;
        logic [63:0] g;
        n = occupied();
        found = -1;
        g = '0;
        case (cmd)
            CMD_SCHED: begin
                if (next_id == ID_INVALID || n >= SLOTS) begin
                    pending_beats.push_back(mk(KIND_SCHED, ID_INVALID, 1'b0, '0, 1'b1));
                end else begin
                    tbl_used[n] = 1'b1;
                    tbl_id[n]   = next_id;
                    tbl_per[n]  = per;
                    tbl_dl[n]   = now + per;
                    tbl_mode[n] = mode;
                    pending_beats.push_back(mk(KIND_SCHED, next_id, 1'b1, '0, 1'b1));
                    issued_ids.push_back(next_id);
                    next_id = next_id + 1'b1;
                end
            end
            CMD_TICK: begin
                for (int i = 0; i < n; i++) begin
                    if (tbl_dl[i] <= now) begin
                        pending_beats.push_back(mk(KIND_FIRED, tbl_id[i], 1'b0, '0, 1'b0));
                        tbl_dl[i] = tbl_mode[i] ? tbl_dl[i] + tbl_per[i] : now + tbl_per[i];
                    end
                end
                pending_beats.push_back(mk(KIND_DONE, ID_INVALID, 1'b0, '0, 1'b1));
            end
            CMD_REM: begin
                for (int i = 0; i < n; i++)
                    if (found < 0 && tbl_id[i] == tid) found = i;
                if (found >= 0) begin
                    for (int j = found; j + 1 < n; j++) begin
                        tbl_id[j]   = tbl_id[j+1];
                        tbl_per[j]  = tbl_per[j+1];
                        tbl_dl[j]   = tbl_dl[j+1];
                        tbl_mode[j] = tbl_mode[j+1];
                    end
                    tbl_used[n-1] = 1'b0;
                end
                pending_beats.push_back(mk(KIND_REM, tid, found >= 0, '0, 1'b1));
            end
            default: begin
                for (int i = 0; i < n; i++)
                    if (tbl_per[i] != 0) g = (g == 0) ? tbl_per[i] : gcd_of(g, tbl_per[i]);
                pending_beats.push_back(mk(KIND_PER, ID_INVALID, 1'b0, g, 1'b1));
            end
        endcase
    endtask

    // offer one command; hold valid until the beat is taken
    task automatic send_cmd(logic [1:0] cmd, logic [63:0] now, logic [63:0] per,
                            logic mode, logic [ID_W-1:0] tid);
        while ($urandom_range(99) < idle_in_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_command  <= cmd;
        i_now_time <= now;
        i_period   <= per;
        i_mode     <= mode;
        i_task_id  <= tid;
        do @(posedge i_clk); while (!o_ready);
        predict_table(cmd, now, per, mode, tid);
    endtask

    // drop valid and wait until every expected beat has come back
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_beats.size() != 0);
    endtask

    // result side: random stall plus an occasional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_sink > 0) begin
            hold_sink <= hold_sink - 1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= idle_out_pct);
        end
    end

    // compare every accepted result beat with the oldest expectation
    always @(posedge i_clk) begin
        t_beat w;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_beats.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat kind=%0d id=%0d", $time, o_kind, o_result_id);
            end else begin
                w = pending_beats.pop_front();
                if (o_kind !== w.kind || o_result_id !== w.rid || o_ok !== w.ok
                        || o_tick_period !== w.tp || o_last !== w.last) begin
                    errors++;
                    $display("%0t: mismatch expected kind=%0d id=%0d ok=%0d tp=%0d last=%0d",
                             $time, w.kind, w.rid, w.ok, w.tp, w.last);
                    $display("%0t:          actual   kind=%0d id=%0d ok=%0d tp=%0d last=%0d",
                             $time, o_kind, o_result_id, o_ok, o_tick_period, o_last);
                end
            end
        end
    end

    // watchdog: cycles without any accepted beat on either side
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // random period: mostly small multiples so GCDs and firings are interesting
    function automatic logic [63:0] rand_period();
        case ($urandom_range(9))
            0:       return '0;
            1:       return rand64();
            2:       return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(3));
            default: return 64'($urandom_range(1, 12)) * 64'($urandom_range(1, 40));
        endcase
    endfunction

    t_row        rows[$];
    logic [63:0] clock_now;

    task automatic add_row(logic [1:0] c, logic [63:0] nw, logic [63:0] p, logic m,
                           logic [ID_W-1:0] t, bit chk, t_beat w);
        t_row r;
        r.cmd = c; r.now = nw; r.per = p; r.mode = m; r.tid = t; r.chk = chk; r.want = w;
        rows.push_back(r);
    endtask

    task automatic random_phase(int count);
        int c;
        logic [ID_W-1:0] t;
        for (int k = 0; k < count; k++) begin
            c = $urandom_range(99);
            clock_now = clock_now + 64'($urandom_range(0, 200));
            if (c < 35) begin
                send_cmd(CMD_SCHED, ($urandom_range(19) == 0) ? rand64() : clock_now,
                         rand_period(), 1'($urandom_range(1)), ID_W'($urandom()));
            end else if (c < 65) begin
                send_cmd(CMD_TICK, ($urandom_range(19) == 0) ? rand64() : clock_now,
                         rand64(), 1'($urandom_range(1)), ID_W'($urandom()));
            end else if (c < 88) begin
                // mostly live or recently issued ids, some garbage
                if (issued_ids.size() != 0 && $urandom_range(3) != 0)
                    t = issued_ids[$urandom_range(issued_ids.size() - 1)];
                else
                    t = ID_W'($urandom());
                send_cmd(CMD_REM, rand64(), rand64(), 1'($urandom_range(1)), t);
            end else begin
                send_cmd(CMD_QUERY, rand64(), rand64(), 1'($urandom_range(1)),
                         ID_W'($urandom()));
            end
        end
    endtask

    initial begin
        t_row r;
        errors       = 0;
        hold_sink    = 0;
        quiet_cycles = 0;
        idle_in_pct  = 0;
        idle_out_pct = 0;
        next_id      = '0;
        clock_now    = 64'd1000;
        for (int i = 0; i < SLOTS; i++) tbl_used[i] = 1'b0;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_command  = CMD_SCHED;
        i_now_time = '0;
        i_period   = '0;
        i_mode     = 1'b0;
        i_task_id  = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty-table answers, extremes, wraparound, both modes
        add_row(CMD_QUERY, '1, '1, 1'b1, '1, 1'b1,
                mk(KIND_PER, ID_INVALID, 1'b0, '0, 1'b1));
        add_row(CMD_TICK,  '1, '0, 1'b0, '0, 1'b1,
                mk(KIND_DONE, ID_INVALID, 1'b0, '0, 1'b1));
        add_row(CMD_REM,   '0, '0, 1'b0, '1, 1'b1,
                mk(KIND_REM, ID_INVALID, 1'b0, '0, 1'b1));
        add_row(CMD_SCHED, 64'd100, 64'd12, 1'b0, '0, 1'b1,
                mk(KIND_SCHED, 31'd0, 1'b1, '0, 1'b1));
        add_row(CMD_SCHED, 64'd100, 64'd18, 1'b1, '0, 1'b1,
                mk(KIND_SCHED, 31'd1, 1'b1, '0, 1'b1));
        add_row(CMD_SCHED, '1, '1, 1'b1, '0, 1'b0, '0);            // deadline wraps
        add_row(CMD_SCHED, 64'd0, 64'd0, 1'b0, '0, 1'b0, '0);      // zero period
        // gcd(12, 18, 2^64-1) = 3
        add_row(CMD_QUERY, '0, '0, 1'b0, '0, 1'b1,
                mk(KIND_PER, ID_INVALID, 1'b0, 64'd3, 1'b1));
        add_row(CMD_TICK,  64'd111, '0, 1'b0, '0, 1'b0, '0);
        add_row(CMD_TICK,  64'd130, '0, 1'b0, '0, 1'b0, '0);
        add_row(CMD_TICK,  '1, '0, 1'b0, '0, 1'b0, '0);
        add_row(CMD_REM,   '0, '0, 1'b0, 31'd1, 1'b1,
                mk(KIND_REM, 31'd1, 1'b1, '0, 1'b1));
        add_row(CMD_REM,   '0, '0, 1'b0, 31'd1, 1'b1,
                mk(KIND_REM, 31'd1, 1'b0, '0, 1'b1));
        add_row(CMD_QUERY, '0, '0, 1'b0, '0, 1'b0, '0);
        for (int i = 0; i < 14; i++)                                // fill table
            add_row(CMD_SCHED, 64'd200, 64'(6 * (i + 1)), i[0], '0, 1'b0, '0);
        add_row(CMD_SCHED, 64'd200, 64'd5, 1'b0, '0, 1'b1,
                mk(KIND_SCHED, ID_INVALID, 1'b0, '0, 1'b1));
        add_row(CMD_TICK,  '1, '0, 1'b0, '0, 1'b0, '0);             // all 16 fire
        add_row(CMD_QUERY, '0, '0, 1'b0, '0, 1'b0, '0);
        add_row(CMD_REM,   '0, '0, 1'b0, 31'd0, 1'b0, '0);

        foreach (rows[k]) begin
            r = rows[k];
            send_cmd(r.cmd, r.now, r.per, r.mode, r.tid);
            if (r.chk) begin
                // hand-typed answer must agree with what the predictor queued
                if (pending_beats.size() == 0) begin
                    errors++;
                    $display("%0t: row %0d expected kind=%0d id=%0d ok=%0d tp=%0d, got none",
                             $time, k, r.want.kind, r.want.rid, r.want.ok, r.want.tp);
                end else if (pending_beats[$] != r.want) begin
                    errors++;
                    $display("%0t: row %0d expected kind=%0d id=%0d ok=%0d tp=%0d", $time, k,
                             r.want.kind, r.want.rid, r.want.ok, r.want.tp);
                    $display("%0t: row %0d actual   kind=%0d id=%0d ok=%0d tp=%0d", $time, k,
                             pending_beats[$].kind, pending_beats[$].rid,
                             pending_beats[$].ok, pending_beats[$].tp);
                end
            end
        end
        drain();

        // empty the table again
        while (occupied() != 0) send_cmd(CMD_REM, '0, '0, 1'b0, tbl_id[0]);
        drain();

        idle_in_pct = 20; idle_out_pct = 68;
        random_phase(40);
        // long sink hold-off while commands keep coming
        hold_sink = 400;
        random_phase(10);
        drain();    // sender pauses until everything is back
        idle_in_pct = 68; idle_out_pct = 20;
        random_phase(40);
        idle_in_pct = 0; idle_out_pct = 0;
        random_phase(45);

        drain();
        repeat (200) @(posedge i_clk);
        if (errors == 0 && pending_beats.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+design
design/ptt_pkg.sv
design/periodic_task_table_unit.sv
tb/sv/tb.sv
